### rtl/core/pcgb_pkg.sv
`default_nettype none
package pcgb_pkg;

  // Default geometry
  localparam int TILE_W_DEF     = 64;
  localparam int TILE_H_DEF     = 64;
  localparam int COUNT_BITS_DEF = 16;

  // Word widths
  localparam int DATA_W = 32;
  localparam int LIN_W  = 22;  // signed row*width+col

  // Commands
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Modes
  localparam logic [2:0] MODE_INTEN = 3'd0;
  localparam logic [2:0] MODE_HIGH  = 3'd1;
  localparam logic [2:0] MODE_LOW   = 3'd2;
  localparam logic [2:0] MODE_RET   = 3'd3;
  localparam logic [2:0] MODE_RGB   = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_NULL   = 2'd3;

  // Unsigned add saturating at all ones
  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[DATA_W] ? {DATA_W{1'b1}} : s[DATA_W-1:0];
  endfunction

  // Clamp to the largest positive signed value
  function automatic logic [DATA_W-1:0] clamp_pos(input logic [DATA_W-1:0] v);
    clamp_pos = v[DATA_W-1] ? {1'b0, {(DATA_W-1){1'b1}}} : v;
  endfunction

endpackage
`default_nettype wire

### rtl/core/pcgb_ram.sv
`default_nettype none
module pcgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/core/pcgb_div.sv
`default_nettype none
module pcgb_div
  import pcgb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output logic                   done,
  output logic      [DATA_W-1:0] quotient
);

  localparam int CW = $clog2(DATA_W + 1);

  logic [DATA_W-1:0] rem_r, quo_r, dsr_r;
  logic [CW-1:0]     step_r;
  logic              run_r, done_r;
  logic [DATA_W:0]   trial;

  // One quotient bit per cycle, restoring
  assign trial = {rem_r, quo_r[DATA_W-1]} - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        dsr_r  <= divisor;
      end else if (run_r) begin
        if (!trial[DATA_W]) begin
          rem_r <= trial[DATA_W-1:0];
          quo_r <= {quo_r[DATA_W-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[DATA_W-2:0], quo_r[DATA_W-1]};
          quo_r <= {quo_r[DATA_W-2:0], 1'b0};
        end
        step_r <= step_r + 1'b1;
        if (step_r == CW'(DATA_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

### rtl/core/point_cloud_grid_binning_top.sv
// Grid binning of projected lidar points into TILE_W*TILE_H buckets held in
// one single-port-write, registered-read RAM. A transaction starts when start
// is high and busy low. Add: latch, index and RAM read, write back. Read:
// latch, index and RAM read, then the result for height and returns modes;
// intensity and RGB means first wait for the bit-serial 32-bit dividers. An
// add or read outside the tile ends after the index step. Clear: a sweep of
// all TILE_W*TILE_H entries, one entry per cycle; the same sweep runs after
// reset, with busy high. A read gives one result on the out_ ports for one
// cycle, marked by out_valid; the receiver cannot stall it, so it must take
// it then. Configuration writes are always taken (cfg_ready is high) and
// must only be issued while busy is low.
`default_nettype none
module point_cloud_grid_binning_top
  import pcgb_pkg::*;
#(
  parameter int TILE_W     = TILE_W_DEF,
  parameter int TILE_H     = TILE_H_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_command,
  input  wire logic signed [12:0] in_col,
  input  wire logic signed [12:0] in_row,
  input  wire logic [15:0]        in_intensity,
  input  wire logic [15:0]        in_red,
  input  wire logic [15:0]        in_green,
  input  wire logic [15:0]        in_blue,
  input  wire logic signed [31:0] in_height,
  input  wire logic [3:0]         in_returns,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  output logic                    out_valid,
  output logic signed [31:0]      out_value_band0,
  output logic signed [31:0]      out_value_band1,
  output logic signed [31:0]      out_value_band2,
  output logic                    out_hit
);

  localparam int DEPTH   = TILE_W * TILE_H;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ENTRY_W = 1 + 3 * DATA_W + COUNT_BITS;
  localparam int C_LO    = COUNT_BITS;
  localparam int B_LO    = COUNT_BITS + DATA_W;
  localparam int A_LO    = COUNT_BITS + 2 * DATA_W;
  localparam int V_BIT   = COUNT_BITS + 3 * DATA_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_IDX  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_CLR  = 3'd4;

  // Configuration registers
  logic [2:0]        mode_r;
  logic [6:0]        tw_r, th_r;
  logic [DATA_W-1:0] null_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_INTEN;
      tw_r   <= 7'd64;
      th_r   <= 7'd64;
      null_r <= 32'h8000_0000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:   mode_r <= cfg_data[2:0];
        REG_WIDTH:  tw_r   <= cfg_data[6:0];
        REG_HEIGHT: th_r   <= cfg_data[6:0];
        REG_NULL:   null_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Effective mode and tile size
  logic [2:0]  mode_eff;
  logic [6:0]  w_eff, h_eff;
  logic [13:0] area_r;

  assign mode_eff = (mode_r > MODE_RGB) ? MODE_INTEN : mode_r;

  always_comb begin
    if (tw_r == 7'd0)                   w_eff = 7'd1;
    else if ({4'd0, tw_r} > 11'(TILE_W)) w_eff = 7'(TILE_W);
    else                                w_eff = tw_r;
    if (th_r == 7'd0)                   h_eff = 7'd1;
    else if ({4'd0, th_r} > 11'(TILE_H)) h_eff = 7'(TILE_H);
    else                                h_eff = th_r;
  end

  always_ff @(posedge clk) begin
    area_r <= w_eff * h_eff;
  end

  // Latched transaction
  logic [1:0]         cmd_r;
  logic signed [12:0] col_r, row_r;
  logic [15:0]        inten_r, red_r, grn_r, blu_r;
  logic [31:0]        hgt_r;
  logic [3:0]         ret_r;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r   <= in_command;
      col_r   <= in_col;
      row_r   <= in_row;
      inten_r <= in_intensity;
      red_r   <= in_red;
      grn_r   <= in_green;
      blu_r   <= in_blue;
      hgt_r   <= in_height;
      ret_r   <= in_returns;
    end
  end

  // Linear index and tile check
  logic signed [LIN_W-1:0] lin;
  logic                    in_tile;

  assign lin = LIN_W'(row_r * $signed({1'b0, w_eff})) + LIN_W'(col_r);
  assign in_tile = !lin[LIN_W-1] && (lin[LIN_W-2:0] < (LIN_W-1)'(area_r));

  // Bucket RAM
  logic [2:0]         state_r;
  logic [AW-1:0]      idx_r, sweep_r;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata, rdata;

  pcgb_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(lin[AW-1:0]),
    .rdata(rdata)
  );

  // Entry fields
  logic                  e_valid;
  logic [DATA_W-1:0]     e_a, e_b, e_c;
  logic [COUNT_BITS-1:0] e_cnt;

  assign e_valid = rdata[V_BIT];
  assign e_a     = rdata[A_LO +: DATA_W];
  assign e_b     = rdata[B_LO +: DATA_W];
  assign e_c     = rdata[C_LO +: DATA_W];
  assign e_cnt   = rdata[COUNT_BITS-1:0];

  // Read-modify-write of an add
  logic [DATA_W-1:0] n_a, n_b, n_c, h32, r32, in_a;
  logic              add_wr;

  assign h32 = hgt_r;
  assign r32 = DATA_W'(ret_r);

  always_comb begin
    case (mode_eff)
      MODE_INTEN: in_a = DATA_W'(inten_r);
      MODE_RET:   in_a = r32;
      MODE_RGB:   in_a = DATA_W'(red_r);
      default:    in_a = h32;
    endcase
    n_a    = e_a;
    n_b    = e_b;
    n_c    = e_c;
    add_wr = 1'b1;
    if (!e_valid) begin
      n_a = in_a;
      n_b = (mode_eff == MODE_RGB) ? DATA_W'(grn_r) : '0;
      n_c = (mode_eff == MODE_RGB) ? DATA_W'(blu_r) : '0;
    end else if (&e_cnt) begin
      add_wr = 1'b0;
    end else begin
      case (mode_eff)
        MODE_HIGH: if ($signed(h32) > $signed(e_a)) n_a = h32;
        MODE_LOW:  if ($signed(h32) < $signed(e_a)) n_a = h32;
        MODE_RGB: begin
          n_a = sat_add(e_a, DATA_W'(red_r));
          n_b = sat_add(e_b, DATA_W'(grn_r));
          n_c = sat_add(e_c, DATA_W'(blu_r));
        end
        default:   n_a = sat_add(e_a, in_a);
      endcase
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx_r;
    wdata = {1'b1, n_a, n_b, n_c,
             e_valid ? e_cnt + 1'b1 : COUNT_BITS'(1)};
    if (state_r == ST_CLR) begin
      we    = 1'b1;
      waddr = sweep_r;
      wdata = '0;
    end else if (state_r == ST_RD && cmd_r == CMD_ADD) begin
      we = add_wr;
    end
  end

  // Mean dividers
  logic              div_start;
  logic [2:0]        div_done;
  logic [DATA_W-1:0] q_a, q_b, q_c, dsr;
  logic [DATA_W-1:0] s_a_r, s_b_r, s_c_r;
  logic              cnt_zero_r;

  assign div_start = (state_r == ST_RD) && (cmd_r == CMD_READ) && e_valid &&
                     (mode_eff == MODE_INTEN || mode_eff == MODE_RGB);
  assign dsr = DATA_W'(e_cnt);

  pcgb_div u_div_a (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(e_a),
                    .divisor(dsr), .done(div_done[0]), .quotient(q_a));
  pcgb_div u_div_b (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(e_b),
                    .divisor(dsr), .done(div_done[1]), .quotient(q_b));
  pcgb_div u_div_c (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(e_c),
                    .divisor(dsr), .done(div_done[2]), .quotient(q_c));

  // Sequencer
  logic              out_valid_r, hit_r;
  logic [DATA_W-1:0] b0_r, b1_r, b2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) state_r <= ST_IDX;
        end
        ST_IDX: begin
          idx_r   <= lin[AW-1:0];
          state_r <= ST_IDLE;
          if (cmd_r == CMD_CLEAR) begin
            sweep_r <= '0;
            state_r <= ST_CLR;
          end else if ((cmd_r == CMD_ADD || cmd_r == CMD_READ) && in_tile) begin
            state_r <= ST_RD;
          end else if (cmd_r == CMD_READ) begin
            out_valid_r <= 1'b1;
            hit_r <= 1'b0;
            b0_r  <= null_r;
            b1_r  <= null_r;
            b2_r  <= null_r;
          end
        end
        ST_RD: begin
          state_r <= ST_IDLE;
          if (cmd_r == CMD_READ) begin
            hit_r      <= e_valid;
            b0_r       <= null_r;
            b1_r       <= null_r;
            b2_r       <= null_r;
            s_a_r      <= e_a;
            s_b_r      <= e_b;
            s_c_r      <= e_c;
            cnt_zero_r <= (e_cnt == '0);
            if (div_start) begin
              state_r <= ST_DIV;
            end else begin
              out_valid_r <= 1'b1;
              if (e_valid) begin
                b0_r <= (mode_eff == MODE_RET) ? clamp_pos(e_a) : e_a;
              end
            end
          end
        end
        ST_DIV: begin
          if (div_done[0]) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            b0_r <= clamp_pos(cnt_zero_r ? s_a_r : q_a);
            if (mode_eff == MODE_RGB) begin
              b1_r <= clamp_pos(cnt_zero_r ? s_b_r : q_b);
              b2_r <= clamp_pos(cnt_zero_r ? s_c_r : q_c);
            end
          end
        end
        ST_CLR: begin
          sweep_r <= sweep_r + 1'b1;
          if (sweep_r == AW'(DEPTH - 1)) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_value_band0 = b0_r;
  assign out_value_band1 = b1_r;
  assign out_value_band2 = b2_r;
  assign out_hit         = hit_r;

  // Checks
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted transaction did not raise busy");
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    div_done[0] == div_done[1] && div_done[1] == div_done[2])
    else $error("dividers out of step");
  a_write_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == ST_CLR || state_r == ST_RD))
    else $error("bucket write outside sweep or update");

endmodule
`default_nettype wire
